@@ sv/sosp_pkg.sv @@
// Package for the set-of-stacks block: transaction types, opcodes, status codes,
// default sizes and the controller/datapath command and status structs.
// No dependencies.
package sosp_pkg;

    localparam int NUM_STACKS_DEF  = 4;
    localparam int STACK_DEPTH_DEF = 256;

    localparam int THR_W = 9;
    localparam logic [THR_W-1:0] THR_RST = 9'd3;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_POP_AT = 2'd2;
    localparam logic [1:0] OP_TOP    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic        [1:0]  opcode;
        logic signed [31:0] push_value;
        logic        [1:0]  stack_index;
    } cmd_t;

    typedef struct packed {
        logic        [1:0]  status;
        logic signed [31:0] top_value;
    } res_t;

    // controller -> datapath
    typedef struct packed {
        logic       load;       // latch the incoming transaction
        logic       rd_fill;    // read fill count (registered)
        logic       rd_idx;     // fill read address from stack_index, else current
        logic       cur_inc;
        logic       cur_dec;
        logic       fill_inc;   // write back fill + 1
        logic       fill_dec;   // write back fill - 1
        logic       elem_wr;    // store push_value at the top slot
        logic       elem_rd;    // read the top element (registered)
        logic       res_valid;
        logic       res_elem;   // result carries the element read
        logic [1:0] res_status;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       idx_oob;
        logic       fill_zero;
        logic       fill_ge_th;
        logic       fill_lt_depth;
        logic       cur_last;
        logic       cur_zero;
    } sts_t;

endpackage

@@ sv/sosp_ctrl.sv @@
// Controller state machine for the set-of-stacks block.
// Depends on sosp_pkg (ctl_t, sts_t, opcodes, status codes).
module sosp_ctrl
    import sosp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  sts_t sts,
    output ctl_t ctl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EV   = 2'd2;
    localparam logic [1:0] S_TOP  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       adv_reg, adv_next;   // push already moved on to the next sub-stack

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            adv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            adv_reg   <= adv_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        adv_next   = adv_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    adv_next   = 1'b0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (sts.opcode == OP_POP_AT && sts.idx_oob)
                begin
                    ctl.res_valid  = 1'b1;
                    ctl.res_status = ST_EMPTY;
                    state_next     = S_IDLE;
                end
                else
                begin
                    ctl.rd_fill = 1'b1;
                    ctl.rd_idx  = (sts.opcode == OP_POP_AT);
                    state_next  = S_EV;
                end
            end
            S_EV:
            begin
                state_next = S_IDLE;
                unique case (sts.opcode) inside
                    OP_PUSH:
                    begin
                        if (!adv_reg && sts.fill_ge_th)
                        begin
                            if (sts.cur_last)
                            begin
                                ctl.res_valid  = 1'b1;
                                ctl.res_status = ST_FULL;
                            end
                            else
                            begin
                                ctl.cur_inc = 1'b1;
                                adv_next    = 1'b1;
                                state_next  = S_RD;
                            end
                        end
                        else if (sts.fill_lt_depth)
                        begin
                            ctl.elem_wr    = 1'b1;
                            ctl.fill_inc   = 1'b1;
                            ctl.res_valid  = 1'b1;
                            ctl.res_status = ST_OK;
                        end
                        else
                        begin
                            ctl.res_valid  = 1'b1;
                            ctl.res_status = ST_FULL;
                        end
                    end
                    OP_POP, OP_TOP:
                    begin
                        if (sts.fill_zero)
                        begin
                            if (sts.cur_zero)
                            begin
                                ctl.res_valid  = 1'b1;
                                ctl.res_status = ST_EMPTY;
                            end
                            else
                            begin
                                ctl.cur_dec = 1'b1;
                                state_next  = S_RD;
                            end
                        end
                        else if (sts.opcode == OP_POP)
                        begin
                            ctl.fill_dec   = 1'b1;
                            ctl.res_valid  = 1'b1;
                            ctl.res_status = ST_OK;
                        end
                        else
                        begin
                            ctl.elem_rd = 1'b1;
                            state_next  = S_TOP;
                        end
                    end
                    OP_POP_AT:
                    begin
                        ctl.res_valid = 1'b1;
                        if (sts.fill_zero)
                        begin
                            ctl.res_status = ST_EMPTY;
                        end
                        else
                        begin
                            ctl.fill_dec   = 1'b1;
                            ctl.res_status = ST_OK;
                        end
                    end
                    default:
                    begin
                        ctl.res_valid  = 1'b1;
                        ctl.res_status = ST_EMPTY;
                    end
                endcase
            end
            S_TOP:
            begin
                ctl.res_valid  = 1'b1;
                ctl.res_elem   = 1'b1;
                ctl.res_status = ST_OK;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/sosp_dp.sv @@
// Datapath for the set-of-stacks block: fill-count memory with valid bits,
// element memory, current pointer, threshold register and result register.
// Depends on sosp_pkg (cmd_t, res_t, ctl_t, sts_t).
module sosp_dp
    import sosp_pkg::*;
#(
    parameter int NUM_STACKS  = NUM_STACKS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic             cfg_wr,
    input  logic [THR_W-1:0] cfg_data,
    input  ctl_t             ctl,
    output sts_t             sts,
    output logic             done,
    output res_t             result
);

    localparam int SW    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int FW    = $clog2(STACK_DEPTH + 1);
    localparam int ELEMS = NUM_STACKS * STACK_DEPTH;
    localparam int AW    = (ELEMS > 1) ? $clog2(ELEMS) : 1;
    localparam int CW    = ((FW > THR_W) ? FW : THR_W) + 1;

    cmd_t             cmd_reg;
    logic [SW-1:0]    cur_reg;
    logic [THR_W-1:0] thr_reg;

    logic [FW-1:0]    fill_mem [NUM_STACKS];
    logic [NUM_STACKS-1:0] fill_vld_reg;
    logic [FW-1:0]    fill_raw_reg;
    logic             fill_hit_reg;
    logic [SW-1:0]    rd_addr_reg;

    logic [31:0]      elem_mem [ELEMS];
    logic [31:0]      elem_q_reg;

    res_t             res_reg;
    logic             done_reg;

    logic [SW-1:0]    idx_addr;
    logic [SW-1:0]    rd_addr;
    logic [FW-1:0]    fill_val;
    logic [FW-1:0]    fill_wdata;
    logic [CW-1:0]    eff_th;
    logic [AW-1:0]    base;
    logic [FW-1:0]    off;
    logic [AW-1:0]    elem_addr;

    assign idx_addr = SW'(cmd_reg.stack_index);
    assign rd_addr  = ctl.rd_idx ? idx_addr : cur_reg;
    assign fill_val = fill_hit_reg ? fill_raw_reg : '0;

    // threshold of zero acts as one, above the depth saturates
    always_comb
    begin
        if (thr_reg == '0)
            eff_th = CW'(1);
        else if (CW'(thr_reg) > CW'(STACK_DEPTH))
            eff_th = CW'(STACK_DEPTH);
        else
            eff_th = CW'(thr_reg);
    end

    assign fill_wdata = ctl.fill_inc ? FW'(fill_val + 1'b1) : FW'(fill_val - 1'b1);
    assign base       = AW'(rd_addr_reg) * AW'(STACK_DEPTH);
    assign off        = ctl.elem_rd ? FW'(fill_val - 1'b1) : fill_val;
    assign elem_addr  = AW'(base + AW'(off));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg      <= '0;
            thr_reg      <= THR_RST;
            fill_vld_reg <= '0;
            fill_hit_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
                thr_reg <= cfg_data;
            if (ctl.cur_inc)
                cur_reg <= SW'(cur_reg + 1'b1);
            else if (ctl.cur_dec)
                cur_reg <= SW'(cur_reg - 1'b1);
            if (ctl.rd_fill)
                fill_hit_reg <= fill_vld_reg[rd_addr];
            if (ctl.fill_inc || ctl.fill_dec)
                fill_vld_reg[rd_addr_reg] <= 1'b1;
            done_reg <= ctl.res_valid;
        end
    end

    // fill-count memory
    always_ff @(posedge clk)
    begin
        if (ctl.rd_fill)
        begin
            fill_raw_reg <= fill_mem[rd_addr];
            rd_addr_reg  <= rd_addr;
        end
        if (ctl.fill_inc || ctl.fill_dec)
            fill_mem[rd_addr_reg] <= fill_wdata;
    end

    // element memory
    always_ff @(posedge clk)
    begin
        if (ctl.elem_wr)
            elem_mem[elem_addr] <= cmd_reg.push_value;
        if (ctl.elem_rd)
            elem_q_reg <= elem_mem[elem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            cmd_reg <= cmd;
        if (ctl.res_valid)
        begin
            res_reg.status    <= ctl.res_status;
            res_reg.top_value <= ctl.res_elem ? elem_q_reg : '0;
        end
    end

    assign sts.opcode        = cmd_reg.opcode;
    assign sts.idx_oob       = (7'(cmd_reg.stack_index) >= 7'(NUM_STACKS));
    assign sts.fill_zero     = (fill_val == '0);
    assign sts.fill_ge_th    = (CW'(fill_val) >= eff_th);
    assign sts.fill_lt_depth = (CW'(fill_val) < CW'(STACK_DEPTH));
    assign sts.cur_last      = (cur_reg == SW'(NUM_STACKS - 1));
    assign sts.cur_zero      = (cur_reg == '0);

    assign done   = done_reg;
    assign result = res_reg;

endmodule

@@ sv/set_of_stacks_with_pop_at.sv @@
// Set of stacks with pop-at: one transaction at a time, done strobes one result.
// The sub-stack fill count is read (registered), then evaluated; a push moves at most
// once to the next sub-stack and rereads, a named pop past the last sub-stack ends
// before the fill read, read top adds a registered element read, and pop and read
// top step back past each empty sub-stack with a new fill read. busy is high until
// the result cycle; the next transaction may start then. Reset (rst_n, async,
// active low) empties all sub-stacks and sets threshold to 3.
module set_of_stacks_with_pop_at
    import sosp_pkg::*;
#(
    parameter int NUM_STACKS  = NUM_STACKS_DEF,   // 1 .. 64
    parameter int STACK_DEPTH = STACK_DEPTH_DEF   // 1 .. 65536
)
(
    input  logic             clk,
    input  logic             rst_n,
    // command channel
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    // result strobe, cannot be stalled
    output logic             done,
    output res_t             result,
    // threshold write channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [THR_W-1:0] cfg_data
);

    ctl_t ctl;
    sts_t sts;

    // threshold is to be written only while idle; the block does not enforce it, so it is always ready
    assign cfg_ready = 1'b1;

    // Controller: sequences fill reads, pointer steps and write-backs.
    sosp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    // Datapath: fill counts (valid bits read empty after reset), element store
    // addressed as sub-stack * depth + slot, and the result register.
    sosp_dp #(
        .NUM_STACKS  (NUM_STACKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg_wr   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .ctl      (ctl),
        .sts      (sts),
        .done     (done),
        .result   (result)
    );

endmodule
